// File: hw/rtl/ptm_pkg.sv
// Package for the power tower modulo unit: widths, datapath command codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package ptm_pkg;

   localparam int CHAIN_DEPTH   = 64;
   localparam int ADDR_W        = $clog2(CHAIN_DEPTH);
   localparam int IDX_W         = $clog2(CHAIN_DEPTH + 1);
   localparam int MOD_W         = 27;
   localparam int VAL_W         = MOD_W + 1;
   localparam int BASE_W        = 63;
   localparam int HGT_W         = 31;
   localparam int DVD_W         = 64;
   localparam int DCNT_W        = $clog2(DVD_W + 1);
   localparam int PRIME_W       = 14;
   localparam int PROD_W        = 2 * MOD_W;
   localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(100000000);

   // Datapath operation codes, one issued per cycle.
   localparam int OP_W = 6;
   localparam logic [OP_W-1:0] OP_NONE     = 6'd0;
   localparam logic [OP_W-1:0] OP_I_LOAD   = 6'd1;
   localparam logic [OP_W-1:0] OP_I_START  = 6'd2;
   localparam logic [OP_W-1:0] OP_B_INIT   = 6'd3;
   localparam logic [OP_W-1:0] OP_B_FINISH = 6'd4;
   localparam logic [OP_W-1:0] OP_T_INIT   = 6'd5;
   localparam logic [OP_W-1:0] OP_DIV_VP   = 6'd6;
   localparam logic [OP_W-1:0] OP_DIV_RP   = 6'd7;
   localparam logic [OP_W-1:0] OP_R_MUL    = 6'd8;
   localparam logic [OP_W-1:0] OP_V_Q      = 6'd9;
   localparam logic [OP_W-1:0] OP_P_INC    = 6'd10;
   localparam logic [OP_W-1:0] OP_DIV_RV   = 6'd11;
   localparam logic [OP_W-1:0] OP_R_MULV   = 6'd12;
   localparam logic [OP_W-1:0] OP_T_STORE  = 6'd13;
   localparam logic [OP_W-1:0] OP_RD       = 6'd14;
   localparam logic [OP_W-1:0] OP_VAL_ONE  = 6'd15;
   localparam logic [OP_W-1:0] OP_VAL_A    = 6'd16;
   localparam logic [OP_W-1:0] OP_DIV_AM   = 6'd17;
   localparam logic [OP_W-1:0] OP_VAL_REMM = 6'd18;
   localparam logic [OP_W-1:0] OP_LVL_DEC  = 6'd19;
   localparam logic [OP_W-1:0] OP_PW_INIT  = 6'd20;
   localparam logic [OP_W-1:0] OP_PW_MUL   = 6'd21;
   localparam logic [OP_W-1:0] OP_PW_STEP  = 6'd22;
   localparam logic [OP_W-1:0] OP_VAL_ACC  = 6'd23;
   localparam logic [OP_W-1:0] OP_MP_B     = 6'd24;
   localparam logic [OP_W-1:0] OP_MP_MULR  = 6'd25;
   localparam logic [OP_W-1:0] OP_DIV_PM   = 6'd26;
   localparam logic [OP_W-1:0] OP_MP_R     = 6'd27;
   localparam logic [OP_W-1:0] OP_MP_MULB  = 6'd28;
   localparam logic [OP_W-1:0] OP_MP_B2    = 6'd29;
   localparam logic [OP_W-1:0] OP_VAL_ACCM = 6'd30;
   localparam logic [OP_W-1:0] OP_DIV_FIN  = 6'd31;
   localparam logic [OP_W-1:0] OP_RES      = 6'd32;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } ptm_cmd_type;

   typedef struct packed {
      logic ready;
      logic n_is_one;
      logic idx_full;
      logic pp_le_v;
      logic v_gt1;
      logic div_done;
      logic rem_zero;
      logic start_is_one;
      logic a_lt_m;
      logic a_le1;
      logic t_zero;
      logic t_lsb;
      logic prod_ge_m;
      logic cnt_zero;
      logic lvl_zero;
   } ptm_sts_type;

endpackage

// File: hw/rtl/ptm_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 27-bit divisor.
// Depends on ptm_pkg.
module ptm_div
   import ptm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [MOD_W-1:0]  divisor,
   output logic              done,
   output logic [DVD_W-1:0]  quotient,
   output logic [MOD_W-1:0]  remainder
);

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [MOD_W-1:0]  dsr_ff, dsr_in;
   logic [MOD_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [MOD_W:0]    trial;
   logic              fits;

   // One shift and conditional subtract per cycle.
   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
         cnt_in = DCNT_W'(DVD_W);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? MOD_W'(trial - {1'b0, dsr_ff}) : trial[MOD_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = (cnt_ff == '0);
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// File: hw/rtl/ptm_dp.sv
// Datapath: modulus register, totient chain memory, shared multiplier and divider,
// and the working registers for chain building and tower evaluation.
// Depends on ptm_pkg and ptm_div.
module ptm_dp
   import ptm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ptm_cmd_type       cmd,
   output ptm_sts_type       sts,
   input  logic [BASE_W-1:0] base,
   input  logic [HGT_W-1:0]  tower_height,
   input  logic              csr_wr_en,
   input  logic [MOD_W-1:0]  csr_wr_data,
   output logic [MOD_W-1:0]  residue
);

   logic [MOD_W-1:0]   chain_mem [CHAIN_DEPTH];

   logic [MOD_W-1:0]   modulus_ff, modulus_in;
   logic [MOD_W-1:0]   eff_mod_ff, eff_mod_in;
   logic               ready_ff, ready_in;
   logic [IDX_W-1:0]   one_lvl_ff, one_lvl_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [MOD_W-1:0]   n_ff, n_in;
   logic [MOD_W-1:0]   r_ff, r_in;
   logic [MOD_W-1:0]   v_ff, v_in;
   logic [PRIME_W-1:0] p_ff, p_in;
   logic [BASE_W-1:0]  a_ff, a_in;
   logic [HGT_W-1:0]   k_ff, k_in;
   logic [IDX_W-1:0]   lvl_ff, lvl_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic [MOD_W-1:0]   m_ff;
   logic [VAL_W-1:0]   t_ff, t_in;
   logic [VAL_W-1:0]   cnt_ff, cnt_in;
   logic [MOD_W-1:0]   acc_ff, acc_in;
   logic [MOD_W-1:0]   b_ff, b_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [MOD_W-1:0]   res_ff, res_in;

   logic [MOD_W-1:0]   eff_mod;
   logic [HGT_W-1:0]   top_lvl;
   logic [MOD_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic [2*PRIME_W-1:0] p_sq;
   logic               div_start;
   logic [DVD_W-1:0]   div_dvd;
   logic [MOD_W-1:0]   div_dsr;
   logic               div_done;
   logic [DVD_W-1:0]   div_q;
   logic [MOD_W-1:0]   div_r;

   ptm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign eff_mod = (modulus_ff < MOD_W'(2)) ? MOD_W'(1) : modulus_ff;
   assign top_lvl = (k_ff == '0) ? '0 : k_ff - 1'b1;
   assign p_sq    = p_ff * p_ff;
   assign mul_p   = mul_a * mul_b;

   // Operand selection for the shared multiplier and divider.
   always_comb begin
      mul_a     = acc_ff;
      mul_b     = a_ff[MOD_W-1:0];
      div_start = 1'b0;
      div_dvd   = {{(DVD_W-MOD_W){1'b0}}, v_ff};
      div_dsr   = {{(MOD_W-PRIME_W){1'b0}}, p_ff};
      case (cmd.op)
         OP_R_MUL: begin
            mul_a = div_q[MOD_W-1:0];
            mul_b = {{(MOD_W-PRIME_W){1'b0}}, p_ff - 1'b1};
         end
         OP_R_MULV: begin
            mul_a = div_q[MOD_W-1:0];
            mul_b = v_ff - 1'b1;
         end
         OP_MP_MULR: begin
            mul_a = acc_ff;
            mul_b = b_ff;
         end
         OP_MP_MULB: begin
            mul_a = b_ff;
            mul_b = b_ff;
         end
         OP_DIV_VP: begin
            div_start = 1'b1;
         end
         OP_DIV_RP: begin
            div_start = 1'b1;
            div_dvd   = {{(DVD_W-MOD_W){1'b0}}, r_ff};
         end
         OP_DIV_RV: begin
            div_start = 1'b1;
            div_dvd   = {{(DVD_W-MOD_W){1'b0}}, r_ff};
            div_dsr   = v_ff;
         end
         OP_DIV_AM: begin
            div_start = 1'b1;
            div_dvd   = {1'b0, a_ff};
            div_dsr   = m_ff;
         end
         OP_DIV_PM: begin
            div_start = 1'b1;
            div_dvd   = {{(DVD_W-PROD_W){1'b0}}, prod_ff};
            div_dsr   = m_ff;
         end
         OP_DIV_FIN: begin
            div_start = 1'b1;
            div_dvd   = {{(DVD_W-VAL_W){1'b0}}, val_ff};
            div_dsr   = eff_mod_ff;
         end
         default: begin
         end
      endcase
   end

   // Register updates for each operation.
   always_comb begin
      modulus_in = modulus_ff;
      eff_mod_in = eff_mod_ff;
      ready_in   = ready_ff;
      one_lvl_in = one_lvl_ff;
      idx_in     = idx_ff;
      n_in       = n_ff;
      r_in       = r_ff;
      v_in       = v_ff;
      p_in       = p_ff;
      a_in       = a_ff;
      k_in       = k_ff;
      lvl_in     = lvl_ff;
      val_in     = val_ff;
      t_in       = t_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      b_in       = b_ff;
      prod_in    = prod_ff;
      res_in     = res_ff;
      case (cmd.op)
         OP_I_LOAD: begin
            a_in = base;
            k_in = tower_height;
         end
         OP_I_START: begin
            lvl_in = (top_lvl < HGT_W'(one_lvl_ff)) ? top_lvl[IDX_W-1:0] : one_lvl_ff;
         end
         OP_B_INIT: begin
            n_in       = eff_mod;
            eff_mod_in = eff_mod;
            idx_in     = IDX_W'(1);
         end
         OP_B_FINISH: begin
            one_lvl_in = (n_ff == MOD_W'(1)) ? idx_ff - 1'b1 : idx_ff;
            ready_in   = 1'b1;
         end
         OP_T_INIT: begin
            r_in = n_ff;
            v_in = n_ff;
            p_in = PRIME_W'(2);
         end
         OP_R_MUL, OP_R_MULV: begin
            r_in = mul_p[MOD_W-1:0];
         end
         OP_V_Q: begin
            v_in = div_q[MOD_W-1:0];
         end
         OP_P_INC: begin
            p_in = p_ff + 1'b1;
         end
         OP_T_STORE: begin
            n_in   = r_ff;
            idx_in = idx_ff + 1'b1;
         end
         OP_VAL_ONE: begin
            val_in = VAL_W'(1);
         end
         OP_VAL_A: begin
            val_in = {1'b0, a_ff[MOD_W-1:0]};
         end
         OP_VAL_REMM: begin
            val_in = {1'b0, div_r} + {1'b0, m_ff};
         end
         OP_LVL_DEC: begin
            lvl_in = lvl_ff - 1'b1;
            t_in   = val_ff;
         end
         OP_PW_INIT: begin
            acc_in = MOD_W'(1);
            cnt_in = t_ff;
         end
         OP_PW_MUL, OP_MP_MULR, OP_MP_MULB: begin
            prod_in = mul_p;
         end
         OP_PW_STEP: begin
            acc_in = prod_ff[MOD_W-1:0];
            cnt_in = cnt_ff - 1'b1;
         end
         OP_VAL_ACC: begin
            val_in = {1'b0, acc_ff};
         end
         OP_MP_B: begin
            b_in   = div_r;
            acc_in = MOD_W'(1);
         end
         OP_MP_R: begin
            acc_in = div_r;
         end
         OP_MP_B2: begin
            b_in = div_r;
            t_in = t_ff >> 1;
         end
         OP_VAL_ACCM: begin
            val_in = {1'b0, acc_ff} + {1'b0, m_ff};
         end
         OP_RES: begin
            res_in = div_r;
         end
         default: begin
         end
      endcase
      // A modulus write invalidates the chain.
      if (csr_wr_en) begin
         modulus_in = csr_wr_data;
         ready_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
         ready_ff   <= 1'b0;
         one_lvl_ff <= '0;
      end else begin
         modulus_ff <= modulus_in;
         ready_ff   <= ready_in;
         one_lvl_ff <= one_lvl_in;
      end
      eff_mod_ff <= eff_mod_in;
      idx_ff     <= idx_in;
      n_ff       <= n_in;
      r_ff       <= r_in;
      v_ff       <= v_in;
      p_ff       <= p_in;
      a_ff       <= a_in;
      k_ff       <= k_in;
      lvl_ff     <= lvl_in;
      val_ff     <= val_in;
      t_ff       <= t_in;
      cnt_ff     <= cnt_in;
      acc_ff     <= acc_in;
      b_ff       <= b_in;
      prod_ff    <= prod_in;
      res_ff     <= res_in;
   end

   // Totient chain memory: one write port, registered read into the level modulus.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_B_INIT) begin
         chain_mem[0] <= eff_mod;
      end else if (cmd.op == OP_T_STORE) begin
         chain_mem[idx_ff[ADDR_W-1:0]] <= r_ff;
      end
      if (cmd.op == OP_RD) begin
         m_ff <= chain_mem[lvl_ff[ADDR_W-1:0]];
      end
   end

   // Status flags toward the controller.
   always_comb begin
      sts.ready        = ready_ff;
      sts.n_is_one     = (n_ff == MOD_W'(1));
      sts.idx_full     = (idx_ff >= IDX_W'(CHAIN_DEPTH));
      sts.pp_le_v      = (p_sq <= {1'b0, v_ff});
      sts.v_gt1        = (v_ff > MOD_W'(1));
      sts.div_done     = div_done;
      sts.rem_zero     = (div_r == '0);
      sts.start_is_one = (lvl_ff == one_lvl_ff);
      sts.a_lt_m       = (a_ff < {{(BASE_W-MOD_W){1'b0}}, m_ff});
      sts.a_le1        = (a_ff < BASE_W'(2));
      sts.t_zero       = (t_ff == '0);
      sts.t_lsb        = t_ff[0];
      sts.prod_ge_m    = (prod_ff >= {{(PROD_W-MOD_W){1'b0}}, m_ff});
      sts.cnt_zero     = (cnt_ff == '0);
      sts.lvl_zero     = (lvl_ff == '0);
   end

   assign residue = res_ff;

   // The chain is only read below the first level whose modulus is one.
   a_rd_in_chain: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_RD |-> lvl_ff < one_lvl_ff)
      else $error("chain read past the stored chain");

   // A chain store never runs past the memory.
   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_T_STORE |-> idx_ff < IDX_W'(CHAIN_DEPTH))
      else $error("chain store out of range");

   // A division is started only when the divider is free.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_done)
      else $error("division started while divider busy");

   // A started division reports busy in the next cycle.
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_done)
      else $error("divider did not start");

endmodule

// File: hw/rtl/ptm_ctrl.sv
// Controller: sequences chain building and tower evaluation on the datapath,
// and owns the stream handshakes and the result valid register.
// Depends on ptm_pkg.
module ptm_ctrl
   import ptm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  ptm_sts_type sts,
   output ptm_cmd_type cmd
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CHK_RDY = 5'd1;
   localparam logic [4:0] S_B_LOOP  = 5'd2;
   localparam logic [4:0] S_T_CHK   = 5'd3;
   localparam logic [4:0] S_T_W1    = 5'd4;
   localparam logic [4:0] S_T_W2    = 5'd5;
   localparam logic [4:0] S_T_STRIP = 5'd6;
   localparam logic [4:0] S_T_W3    = 5'd7;
   localparam logic [4:0] S_T_W4    = 5'd8;
   localparam logic [4:0] S_T_FIN   = 5'd9;
   localparam logic [4:0] S_TOP     = 5'd10;
   localparam logic [4:0] S_TOPM    = 5'd11;
   localparam logic [4:0] S_TOPW    = 5'd12;
   localparam logic [4:0] S_LVL     = 5'd13;
   localparam logic [4:0] S_RD      = 5'd14;
   localparam logic [4:0] S_CLAMP   = 5'd15;
   localparam logic [4:0] S_PWM     = 5'd16;
   localparam logic [4:0] S_PWC     = 5'd17;
   localparam logic [4:0] S_PWD     = 5'd18;
   localparam logic [4:0] S_MPB     = 5'd19;
   localparam logic [4:0] S_MPC     = 5'd20;
   localparam logic [4:0] S_MPR1    = 5'd21;
   localparam logic [4:0] S_MPR2    = 5'd22;
   localparam logic [4:0] S_MPS0    = 5'd23;
   localparam logic [4:0] S_MPS1    = 5'd24;
   localparam logic [4:0] S_MPS2    = 5'd25;
   localparam logic [4:0] S_FINW    = 5'd26;
   localparam logic [4:0] S_OUT     = 5'd27;

   logic [4:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       load_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   // Next state and command for each step.
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      load_rsp = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_I_LOAD;
               state_in = S_CHK_RDY;
            end
         end
         S_CHK_RDY: begin
            if (sts.ready) begin
               cmd.op   = OP_I_START;
               state_in = S_TOP;
            end else begin
               cmd.op   = OP_B_INIT;
               state_in = S_B_LOOP;
            end
         end
         // Totient chain: trial division of each element.
         S_B_LOOP: begin
            if (sts.idx_full || sts.n_is_one) begin
               cmd.op   = OP_B_FINISH;
               state_in = S_CHK_RDY;
            end else begin
               cmd.op   = OP_T_INIT;
               state_in = S_T_CHK;
            end
         end
         S_T_CHK: begin
            if (sts.pp_le_v) begin
               cmd.op   = OP_DIV_VP;
               state_in = S_T_W1;
            end else if (sts.v_gt1) begin
               cmd.op   = OP_DIV_RV;
               state_in = S_T_W4;
            end else begin
               cmd.op   = OP_T_STORE;
               state_in = S_B_LOOP;
            end
         end
         S_T_W1: begin
            if (sts.div_done) begin
               if (sts.rem_zero) begin
                  cmd.op   = OP_DIV_RP;
                  state_in = S_T_W2;
               end else begin
                  cmd.op   = OP_P_INC;
                  state_in = S_T_CHK;
               end
            end
         end
         S_T_W2: begin
            if (sts.div_done) begin
               cmd.op   = OP_R_MUL;
               state_in = S_T_STRIP;
            end
         end
         S_T_STRIP: begin
            cmd.op   = OP_DIV_VP;
            state_in = S_T_W3;
         end
         S_T_W3: begin
            if (sts.div_done) begin
               if (sts.rem_zero) begin
                  cmd.op   = OP_V_Q;
                  state_in = S_T_STRIP;
               end else begin
                  cmd.op   = OP_P_INC;
                  state_in = S_T_CHK;
               end
            end
         end
         S_T_W4: begin
            if (sts.div_done) begin
               cmd.op   = OP_R_MULV;
               state_in = S_T_FIN;
            end
         end
         S_T_FIN: begin
            cmd.op   = OP_T_STORE;
            state_in = S_B_LOOP;
         end
         // Top level of the tower.
         S_TOP: begin
            if (sts.start_is_one) begin
               cmd.op   = OP_VAL_ONE;
               state_in = S_LVL;
            end else begin
               cmd.op   = OP_RD;
               state_in = S_TOPM;
            end
         end
         S_TOPM: begin
            if (sts.a_lt_m) begin
               cmd.op   = OP_VAL_A;
               state_in = S_LVL;
            end else begin
               cmd.op   = OP_DIV_AM;
               state_in = S_TOPW;
            end
         end
         S_TOPW: begin
            if (sts.div_done) begin
               cmd.op   = OP_VAL_REMM;
               state_in = S_LVL;
            end
         end
         // Walk down one level, or finish at the outer modulus.
         S_LVL: begin
            if (sts.lvl_zero) begin
               cmd.op   = OP_DIV_FIN;
               state_in = S_FINW;
            end else begin
               cmd.op   = OP_LVL_DEC;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.op   = OP_RD;
            state_in = S_CLAMP;
         end
         // Saturating size test of the exact power.
         S_CLAMP: begin
            if (sts.t_zero) begin
               cmd.op   = OP_VAL_ONE;
               state_in = S_LVL;
            end else if (sts.a_le1) begin
               cmd.op   = OP_VAL_A;
               state_in = S_LVL;
            end else if (!sts.a_lt_m) begin
               cmd.op   = OP_DIV_AM;
               state_in = S_MPB;
            end else begin
               cmd.op   = OP_PW_INIT;
               state_in = S_PWM;
            end
         end
         S_PWM: begin
            cmd.op   = OP_PW_MUL;
            state_in = S_PWC;
         end
         S_PWC: begin
            if (sts.prod_ge_m) begin
               cmd.op   = OP_DIV_AM;
               state_in = S_MPB;
            end else begin
               cmd.op   = OP_PW_STEP;
               state_in = S_PWD;
            end
         end
         S_PWD: begin
            if (sts.cnt_zero) begin
               cmd.op   = OP_VAL_ACC;
               state_in = S_LVL;
            end else begin
               cmd.op   = OP_PW_MUL;
               state_in = S_PWC;
            end
         end
         // Square-and-multiply exponentiation, exponent bits from the bottom.
         S_MPB: begin
            if (sts.div_done) begin
               cmd.op   = OP_MP_B;
               state_in = S_MPC;
            end
         end
         S_MPC: begin
            if (sts.t_zero) begin
               cmd.op   = OP_VAL_ACCM;
               state_in = S_LVL;
            end else if (sts.t_lsb) begin
               cmd.op   = OP_MP_MULR;
               state_in = S_MPR1;
            end else begin
               cmd.op   = OP_MP_MULB;
               state_in = S_MPS1;
            end
         end
         S_MPR1: begin
            cmd.op   = OP_DIV_PM;
            state_in = S_MPR2;
         end
         S_MPR2: begin
            if (sts.div_done) begin
               cmd.op   = OP_MP_R;
               state_in = S_MPS0;
            end
         end
         S_MPS0: begin
            cmd.op   = OP_MP_MULB;
            state_in = S_MPS1;
         end
         S_MPS1: begin
            cmd.op   = OP_DIV_PM;
            state_in = S_MPS2;
         end
         S_MPS2: begin
            if (sts.div_done) begin
               cmd.op   = OP_MP_B2;
               state_in = S_MPC;
            end
         end
         S_FINW: begin
            if (sts.div_done) begin
               state_in = S_OUT;
            end
         end
         // Load the output register once the previous result is gone.
         S_OUT: begin
            if (!valid_ff || rsp_tready) begin
               cmd.op   = OP_RES;
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid: set on load, cleared by a transfer.
   always_comb begin
      valid_in = valid_ff;
      if (load_rsp) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // An accepted request always goes on to the chain check.
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_CHK_RDY)
      else $error("accepted request did not start");

   // A result is loaded only when the output register is free or draining.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !valid_ff || rsp_tready)
      else $error("result overwritten");

   // The tower is evaluated only on a ready chain.
   a_chain_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_I_START |-> sts.ready)
      else $error("evaluation on stale chain");

endmodule

// File: hw/rtl/power_tower_modulo_unit.sv
// Power tower modulo unit: one item at a time. After a modulus write the first item
// rebuilds the totient chain by trial division on the shared divider, up to
// sqrt(chain element) trial divisors per element. Each tower level then takes up to
// 28 exponent bits of up to two multiply-divide steps each.
// Synchronous reset clears control, restores modulus 100000000 and marks the chain stale.
module power_tower_modulo_unit
   import ptm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // [62:0] base, [93:63] tower_height, rest zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [26:0] residue, rest zero
   input  logic         csr_wr_en,
   input  logic [26:0]  csr_wr_data  // modulus
);

   ptm_cmd_type       cmd;
   ptm_sts_type       sts;
   logic [MOD_W-1:0]  residue;

   ptm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ptm_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .base         (req_tdata[BASE_W-1:0]),
      .tower_height (req_tdata[BASE_W+HGT_W-1:BASE_W]),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .residue      (residue)
   );

   assign rsp_tdata = {{(32-MOD_W){1'b0}}, residue};

endmodule
